// ----- hdl/udfu_pkg.sv -----
// Shared types, codes and the allowed-transition table for the USB DFU state tracker.
// Depends on nothing; every other file of the block imports it.
package udfu_pkg;

  localparam int unsigned NumStates = 11;

  typedef enum logic [3:0] {
    ST_APP_IDLE   = 4'd0,
    ST_APP_DETACH = 4'd1,
    ST_IDLE       = 4'd2,
    ST_DN_SYNC    = 4'd3,
    ST_DN_BUSY    = 4'd4,
    ST_DN_IDLE    = 4'd5,
    ST_MAN_SYNC   = 4'd6,
    ST_MAN        = 4'd7,
    ST_MAN_WAIT   = 4'd8,
    ST_UP_IDLE    = 4'd9,
    ST_ERROR      = 4'd10
  } state_e;

  typedef enum logic [3:0] {
    CMD_DETACH        = 4'd0,
    CMD_DNLOAD        = 4'd1,
    CMD_UPLOAD        = 4'd2,
    CMD_GETSTATUS     = 4'd3,
    CMD_CLRSTATUS     = 4'd4,
    CMD_GETSTATE      = 4'd5,
    CMD_ABORT         = 4'd6,
    CMD_USBRESET      = 4'd7,
    CMD_POLLTIMEOUT   = 4'd8,
    CMD_DETACHTIMEOUT = 4'd9,
    CMD_INVALID       = 4'd10,
    CMD_POWERRESET    = 4'd11,
    CMD_FORCE         = 4'd12,
    CMD_CHECKED       = 4'd13
  } cmd_e;

  typedef enum logic [1:0] {
    REG_CAN_DOWNLOAD      = 2'd0,
    REG_CAN_UPLOAD        = 2'd1,
    REG_MANIFEST_TOLERANT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic can_download;
    logic can_upload;
    logic manifest_tolerant;
  } cfg_t;

  typedef struct packed {
    logic wlength_nonzero;
    logic short_frame;
    logic block_busy;
    logic manifest_busy;
    logic detach_elapsed;
    logic firmware_valid;
    logic length_mismatch;
  } guard_t;

  typedef struct packed {
    state_e next_state;
    logic   accepted;
    logic   event_known;
  } res_t;

  function automatic logic [NumStates-1:0] st_bit(state_e s);
    st_bit = NumStates'(1) << s;
  endfunction

  // Set of states that may follow a given state, used by the checked set.
  function automatic logic [NumStates-1:0] allowed_next(state_e s);
    logic [NumStates-1:0] v;
    unique case (s)
      ST_APP_IDLE:   v = st_bit(ST_APP_DETACH) | st_bit(ST_APP_IDLE);
      ST_APP_DETACH: v = st_bit(ST_APP_IDLE) | st_bit(ST_IDLE) | st_bit(ST_APP_DETACH);
      ST_IDLE:       v = st_bit(ST_IDLE) | st_bit(ST_DN_SYNC) | st_bit(ST_UP_IDLE)
                         | st_bit(ST_ERROR);
      ST_DN_SYNC:    v = st_bit(ST_DN_SYNC) | st_bit(ST_IDLE) | st_bit(ST_DN_IDLE)
                         | st_bit(ST_DN_BUSY) | st_bit(ST_ERROR);
      ST_DN_BUSY:    v = st_bit(ST_DN_SYNC) | st_bit(ST_ERROR);
      ST_DN_IDLE:    v = st_bit(ST_DN_IDLE) | st_bit(ST_IDLE) | st_bit(ST_DN_SYNC)
                         | st_bit(ST_MAN_SYNC) | st_bit(ST_ERROR);
      ST_MAN_SYNC:   v = st_bit(ST_MAN_SYNC) | st_bit(ST_IDLE) | st_bit(ST_MAN)
                         | st_bit(ST_ERROR);
      ST_MAN:        v = st_bit(ST_MAN_SYNC) | st_bit(ST_MAN_WAIT) | st_bit(ST_ERROR);
      ST_MAN_WAIT:   v = st_bit(ST_ERROR);
      ST_UP_IDLE:    v = st_bit(ST_UP_IDLE) | st_bit(ST_IDLE) | st_bit(ST_ERROR);
      ST_ERROR:      v = st_bit(ST_IDLE) | st_bit(ST_ERROR);
      default:       v = '0;
    endcase
    allowed_next = v;
  endfunction

endpackage

// ----- hdl/usb_dfu_state_tracker.sv -----
// Top level of the USB DFU 1.0/1.1 class state tracker: input register, state,
// result register. Depends on udfu_pkg, udfu_cfg_regs and udfu_next_state.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   cmd_i, guard bits, new_state_i
//   out      source     out_valid_o / out_stall_i next_state_o, accepted_o, event_known_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is accepted every cycle while in_stall_o is low. An accepted item is held
// in the input register and then loaded into the result register, which drives
// out_valid_o; a stall at the output can keep it waiting in the input register.
// The DFU state is updated when an item moves from the input register into
// the result register, so the following item already sees it.
// Reset (rst_ni low, asynchronous) puts the state in dfuERROR, restores the
// attribute defaults and empties both registers.
// A stall at the output holds the result; the input register keeps its item
// and in_stall_o rises only when both registers are full.
module usb_dfu_state_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input item channel.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] cmd_i,
  input  logic       wlength_nonzero_i,
  input  logic       short_frame_i,
  input  logic       block_busy_i,
  input  logic       manifest_busy_i,
  input  logic       detach_elapsed_i,
  input  logic       firmware_valid_i,
  input  logic       length_mismatch_i,
  input  logic [3:0] new_state_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] next_state_o,
  output logic       accepted_o,
  output logic       event_known_o,
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i
);
  import udfu_pkg::*;

  cfg_t cfg;

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [3:0] s1_cmd_q;
  guard_t     s1_guard_q;
  logic [3:0] s1_new_state_q;

  // Current DFU state.
  state_e state_q, state_d;

  // Result register.
  logic out_valid_q, out_valid_d;
  res_t out_res_q;
  res_t res;

  logic s1_adv;
  logic in_take;

  udfu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  udfu_next_state u_next (
    .state_i     (state_q),
    .cmd_i       (s1_cmd_q),
    .guard_i     (s1_guard_q),
    .new_state_i (s1_new_state_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // The input register moves on whenever the result register is free or being emptied.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_take || (s1_valid_q && !s1_adv);
    out_valid_d = s1_adv || (out_valid_q && out_stall_i);
    state_d     = s1_adv ? res.next_state : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_ERROR;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q       <= cmd_i;
      s1_new_state_q <= new_state_i;
      s1_guard_q     <= '{wlength_nonzero: wlength_nonzero_i,
                          short_frame:     short_frame_i,
                          block_busy:      block_busy_i,
                          manifest_busy:   manifest_busy_i,
                          detach_elapsed:  detach_elapsed_i,
                          firmware_valid:  firmware_valid_i,
                          length_mismatch: length_mismatch_i};
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_state_o  = out_res_q.next_state;
  assign accepted_o    = out_res_q.accepted;
  assign event_known_o = out_res_q.event_known;

  // The held state always matches the most recently produced result.
  a_state_matches_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (state_q == out_res_q.next_state))
    else $error("state register differs from the result just produced");

  // A rejected item leaves the state untouched.
  a_reject_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !res.accepted) |=> $stable(state_q))
    else $error("state changed on a rejected item");

  // Without an item in the input register the state cannot move.
  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(state_q))
    else $error("state changed with no item in flight");

  // Input is held off only when both registers are occupied and the output stalls.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while a register was free");

endmodule

// ----- hdl/udfu_cfg_regs.sv -----
// Device attribute registers of the USB DFU state tracker.
// Depends on udfu_pkg for the register indexes and the cfg_t bundle.
module udfu_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic          cfg_data_i,
  output udfu_pkg::cfg_t cfg_o
);
  import udfu_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CAN_DOWNLOAD:      cfg_d.can_download      = cfg_data_i;
        REG_CAN_UPLOAD:        cfg_d.can_upload        = cfg_data_i;
        REG_MANIFEST_TOLERANT: cfg_d.manifest_tolerant = cfg_data_i;
        default:               cfg_d = cfg_q;  // Index beyond the list is ignored.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{can_download: 1'b1, can_upload: 1'b1, manifest_tolerant: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/udfu_next_state.sv -----
// Combinational next-state logic of the DFU class state machine.
// Depends on udfu_pkg for states, commands, guards and the transition table.
module udfu_next_state (
  input  udfu_pkg::state_e state_i,
  input  logic [3:0]       cmd_i,
  input  udfu_pkg::guard_t guard_i,
  input  logic [3:0]       new_state_i,
  input  udfu_pkg::cfg_t   cfg_i,
  output udfu_pkg::res_t   res_o
);
  import udfu_pkg::*;

  state_e               ev_nxt;
  logic                 ev_ok;
  logic                 ev_known;
  logic                 is_reset;
  state_e               after_reset;
  logic                 prop_ok;
  logic [NumStates-1:0] allow_vec;

  assign is_reset    = (cmd_i == CMD_USBRESET) || (cmd_i == CMD_POWERRESET);
  assign after_reset = guard_i.firmware_valid ? ST_APP_IDLE : ST_ERROR;
  assign allow_vec   = allowed_next(state_i);
  assign prop_ok     = (new_state_i <= ST_ERROR);

  // Event transitions; only meaningful when cmd_i is a DFU event code.
  always_comb begin
    ev_nxt   = state_i;
    ev_ok    = 1'b1;
    ev_known = 1'b1;
    priority if (state_i == ST_APP_IDLE) begin
      if (cmd_i == CMD_DETACH) begin
        ev_nxt = ST_APP_DETACH;
      end else if (cmd_i == CMD_GETSTATUS || cmd_i == CMD_GETSTATE) begin
        ev_nxt = state_i;
      end else begin
        ev_ok    = 1'b0;
        ev_known = 1'b0;
      end
    end else if (state_i == ST_APP_DETACH) begin
      if (cmd_i == CMD_GETSTATUS || cmd_i == CMD_GETSTATE) begin
        ev_nxt = state_i;
      end else if (cmd_i == CMD_POWERRESET) begin
        ev_nxt = ST_IDLE;
      end else if (cmd_i == CMD_USBRESET) begin
        ev_nxt = guard_i.detach_elapsed ? ST_APP_IDLE : ST_IDLE;
      end else begin
        ev_nxt = ST_APP_IDLE;
      end
    end else if (is_reset) begin
      // All DFU-mode states treat a USB or power reset alike.
      ev_nxt = after_reset;
    end else begin
      unique case (state_i)
        ST_IDLE: begin
          if (cmd_i == CMD_DNLOAD) begin
            ev_nxt = (guard_i.wlength_nonzero && cfg_i.can_download) ? ST_DN_SYNC : ST_ERROR;
          end else if (cmd_i == CMD_UPLOAD) begin
            ev_nxt = cfg_i.can_upload ? ST_UP_IDLE : ST_ERROR;
          end else if (cmd_i == CMD_ABORT || cmd_i == CMD_GETSTATUS
                       || cmd_i == CMD_GETSTATE) begin
            ev_nxt = ST_IDLE;
          end else begin
            ev_nxt = ST_ERROR;
          end
        end
        ST_DN_SYNC: begin
          if (cmd_i == CMD_GETSTATUS) begin
            ev_nxt = guard_i.block_busy ? ST_DN_BUSY : ST_DN_IDLE;
          end else if (cmd_i == CMD_GETSTATE) begin
            ev_nxt = state_i;
          end else if (cmd_i == CMD_ABORT) begin
            ev_nxt = ST_IDLE;
          end else begin
            ev_nxt = ST_ERROR;
          end
        end
        ST_DN_BUSY: begin
          ev_nxt = (cmd_i == CMD_POLLTIMEOUT) ? ST_DN_SYNC : ST_ERROR;
        end
        ST_DN_IDLE: begin
          if (cmd_i == CMD_DNLOAD) begin
            if (guard_i.wlength_nonzero) begin
              ev_nxt = ST_DN_SYNC;
            end else begin
              ev_nxt = guard_i.length_mismatch ? ST_ERROR : ST_MAN_SYNC;
            end
          end else if (cmd_i == CMD_ABORT) begin
            ev_nxt = ST_IDLE;
          end else if (cmd_i == CMD_GETSTATUS || cmd_i == CMD_GETSTATE) begin
            ev_nxt = state_i;
          end else begin
            ev_nxt = ST_ERROR;
          end
        end
        ST_MAN_SYNC: begin
          if (cmd_i == CMD_GETSTATUS) begin
            if (guard_i.manifest_busy) begin
              ev_nxt = ST_MAN;
            end else begin
              ev_nxt = cfg_i.manifest_tolerant ? ST_IDLE : ST_ERROR;
            end
          end else if (cmd_i == CMD_GETSTATE) begin
            ev_nxt = state_i;
          end else if (cmd_i == CMD_ABORT) begin
            ev_nxt = ST_IDLE;
          end else begin
            ev_nxt = ST_ERROR;
          end
        end
        ST_MAN: begin
          if (cmd_i == CMD_POLLTIMEOUT) begin
            ev_nxt = cfg_i.manifest_tolerant ? ST_MAN_SYNC : ST_MAN_WAIT;
          end else begin
            ev_nxt = ST_ERROR;
          end
        end
        ST_MAN_WAIT: begin
          // Only a reset leaves this state; anything else is unknown but holds.
          ev_known = 1'b0;
          ev_nxt   = ST_MAN_WAIT;
        end
        ST_UP_IDLE: begin
          if (cmd_i == CMD_UPLOAD) begin
            if (guard_i.wlength_nonzero && !guard_i.short_frame) begin
              ev_nxt = ST_UP_IDLE;
            end else if (guard_i.short_frame) begin
              ev_nxt = ST_IDLE;
            end else begin
              ev_nxt = ST_ERROR;
            end
          end else if (cmd_i == CMD_ABORT) begin
            ev_nxt = ST_IDLE;
          end else if (cmd_i == CMD_GETSTATUS || cmd_i == CMD_GETSTATE) begin
            ev_nxt = state_i;
          end else begin
            ev_nxt = ST_ERROR;
          end
        end
        ST_ERROR: begin
          if (cmd_i == CMD_GETSTATUS || cmd_i == CMD_GETSTATE) begin
            ev_nxt = state_i;
          end else if (cmd_i == CMD_CLRSTATUS) begin
            ev_nxt = ST_IDLE;
          end else begin
            ev_nxt = ST_ERROR;
          end
        end
        default: begin
          ev_ok    = 1'b0;
          ev_known = 1'b0;
        end
      endcase
    end
  end

  // Command selection: DFU events, forced load, checked set, or nothing.
  always_comb begin
    res_o = '{next_state: state_i, accepted: 1'b0, event_known: 1'b0};
    if (cmd_i <= CMD_POWERRESET) begin
      res_o.event_known = ev_known;
      res_o.accepted    = ev_ok;
      if (ev_ok) begin
        res_o.next_state = ev_nxt;
      end
    end else if (cmd_i == CMD_FORCE) begin
      if (prop_ok) begin
        res_o.next_state = state_e'(new_state_i);
        res_o.accepted   = 1'b1;
      end
    end else if (cmd_i == CMD_CHECKED) begin
      if (prop_ok && allow_vec[new_state_i]) begin
        res_o.next_state = state_e'(new_state_i);
        res_o.accepted   = 1'b1;
      end
    end
  end

endmodule
